@@ src/baro_pressure_temp_compensation_macros.svh @@
// assertion macros used by the checker file
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH

// property checked on every clock edge outside reset
`define BPTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// property checked on every clock edge, reset included
`define BPTC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ src/bptc_pkg.sv @@
package bptc_pkg;

    // field widths
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 30;
    localparam int DT_W    = 25;
    localparam int PROD_W  = 42;
    localparam int DD_W    = 50;
    localparam int DL_W    = 18;
    localparam int DV_W    = 19;
    localparam int SQ_W    = 35;
    localparam int WIDE_W  = 42;
    localparam int IDX_W   = 3;

    // compensation constants
    localparam int TEMP_REF   = 2000;
    localparam int TEMP_LOW   = -1500;
    localparam int SH_TEMP    = 23;
    localparam int SH_T2      = 31;
    localparam int SH_PROD    = 21;
    localparam int SH_PRES    = 15;
    localparam int SH_OFF     = 7;
    localparam int SH_SENS    = 8;
    localparam int OFF_SCALE  = 16;
    localparam int SENS_SCALE = 15;
    localparam int C5_SCALE   = 8;
    localparam int SENS_LO_W  = 20;

    // register map
    typedef enum logic [IDX_W-1:0] {
        REG_C1    = 3'd0,
        REG_C2    = 3'd1,
        REG_C3    = 3'd2,
        REG_C4    = 3'd3,
        REG_C5    = 3'd4,
        REG_C6    = 3'd5,
        REG_READY = 3'd6
    } bptc_reg_t;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
        logic             ready;
    } bptc_cal_t;

    // first-order terms handed to the second-order stages
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic                     ok;
        logic                     low;
        logic                     vlow;
        logic signed [DL_W-1:0]   dl;
        logic signed [DV_W-1:0]   dv;
        logic signed [TEMP_W-1:0] temp1;
        logic [DL_W-1:0]          t2;
        logic signed [WIDE_W-1:0] off1;
        logic signed [WIDE_W-1:0] sens1;
    } bptc_fo_t;

    // corrected terms handed to the pressure stages
    typedef struct packed {
        logic [RAW_W-1:0]           d1;
        logic                       ok;
        logic signed [TEMP_W:0]     temp;
        logic signed [WIDE_W-1:0]   off;
        logic signed [WIDE_W-1:0]   sens;
    } bptc_so_t;

endpackage

@@ src/baro_pressure_temp_compensation.sv @@
// Barometer compensation pipeline: takes one raw pressure/temperature conversion pair per
// clock and returns temperature in 0.01 C and pressure in 0.01 mbar, with second-order
// correction below 20 C and a further term below -15 C. An accepted item passes stages s1
// to s9 on its way to m_*; one item per cycle is sustained, limited only by the
// nine-stage pipeline advancing as a whole, which holds while m_valid is high and m_ready
// is low. Calibration words are to be written through cfg_we/cfg_index/cfg_wdata only
// while no item is in flight, which the block itself does not enforce; with the calibration
// ready bit clear, results carry m_result_valid low and zero values.
module baro_pressure_temp_compensation (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [bptc_pkg::IDX_W-1:0]          cfg_index,
    input  logic [bptc_pkg::CAL_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bptc_pkg::RAW_W-1:0]          s_raw_pressure,
    input  logic [bptc_pkg::RAW_W-1:0]          s_raw_temperature,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bptc_pkg::TEMP_W-1:0]  m_temperature_centi,
    output logic signed [bptc_pkg::PRES_W-1:0]  m_pressure_centi,
    output logic                                m_result_valid
);
    import bptc_pkg::*;

    bptc_cal_t cal;
    bptc_fo_t  fo;
    bptc_so_t  so;
    logic      fo_valid;
    logic      so_valid;
    logic      en;

    // whole pipeline moves when the output slot is free or being taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    bptc_cal_regs u_cal (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cal       (cal)
    );

    bptc_first_order u_first (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .d1        (s_raw_pressure),
        .d2        (s_raw_temperature),
        .cal       (cal),
        .out_valid (fo_valid),
        .out       (fo)
    );

    bptc_second_order u_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fo_valid),
        .fo        (fo),
        .out_valid (so_valid),
        .out       (so)
    );

    bptc_pressure u_pres (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (en),
        .in_valid          (so_valid),
        .so                (so),
        .out_valid         (m_valid),
        .temperature_centi (m_temperature_centi),
        .pressure_centi    (m_pressure_centi),
        .result_valid      (m_result_valid)
    );

endmodule

@@ src/bptc_cal_regs.sv @@
module bptc_cal_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bptc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bptc_pkg::CAL_W-1:0]     cfg_wdata,
    output bptc_pkg::bptc_cal_t            cal
);
    import bptc_pkg::*;

    bptc_cal_t cal_reg, cal_next;

    // register write decode, unknown index ignored
    always_comb begin
        cal_next = cal_reg;
        if (cfg_we) begin
            unique case (bptc_reg_t'(cfg_index))
                REG_C1:    cal_next.c1 = cfg_wdata;
                REG_C2:    cal_next.c2 = cfg_wdata;
                REG_C3:    cal_next.c3 = cfg_wdata;
                REG_C4:    cal_next.c4 = cfg_wdata;
                REG_C5:    cal_next.c5 = cfg_wdata;
                REG_C6:    cal_next.c6 = cfg_wdata;
                REG_READY: cal_next.ready = cfg_wdata[0];
                default:   cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

@@ src/bptc_first_order.sv @@
module bptc_first_order (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [bptc_pkg::RAW_W-1:0]     d1,
    input  logic [bptc_pkg::RAW_W-1:0]     d2,
    input  bptc_pkg::bptc_cal_t            cal,
    output logic                           out_valid,
    output bptc_pkg::bptc_fo_t             out
);
    import bptc_pkg::*;

    // stage 1: temperature difference
    logic                     s1_valid_reg;
    logic [RAW_W-1:0]         s1_d1_reg;
    logic                     s1_ok_reg;
    logic signed [DT_W-1:0]   s1_dt_reg;
    logic signed [DT_W-1:0]   s1_dt_next;

    // stage 2: products with dt
    logic                     s2_valid_reg;
    logic [RAW_W-1:0]         s2_d1_reg;
    logic                     s2_ok_reg;
    logic signed [PROD_W-1:0] s2_mt_reg, s2_mt_next;
    logic signed [PROD_W-1:0] s2_moff_reg, s2_moff_next;
    logic signed [PROD_W-1:0] s2_msens_reg, s2_msens_next;
    logic signed [DD_W-1:0]   s2_mdd_reg, s2_mdd_next;

    // stage 3: first-order temperature, offset and sensitivity
    logic                     s3_valid_reg;
    bptc_fo_t                 s3_reg, s3_next;
    logic signed [DL_W-1:0]   dl;

    assign s1_dt_next = $signed({1'b0, d2})
                      - $signed({1'b0, cal.c5, {C5_SCALE{1'b0}}});

    assign s2_mt_next    = s1_dt_reg * $signed({1'b0, cal.c6});
    assign s2_moff_next  = s1_dt_reg * $signed({1'b0, cal.c4});
    assign s2_msens_next = s1_dt_reg * $signed({1'b0, cal.c3});
    assign s2_mdd_next   = s1_dt_reg * s1_dt_reg;

    // dt * c6 stays below 2^40, so the shifted value fits 18 bits
    assign dl = s2_mt_reg[SH_TEMP+DL_W-1:SH_TEMP];

    always_comb begin
        s3_next       = '0;
        s3_next.d1    = s2_d1_reg;
        s3_next.ok    = s2_ok_reg;
        s3_next.dl    = dl;
        s3_next.temp1 = TEMP_W'(TEMP_REF) + TEMP_W'(dl);
        s3_next.dv    = DV_W'(s3_next.temp1) - DV_W'(TEMP_LOW);
        s3_next.low   = dl[DL_W-1];
        s3_next.vlow  = s3_next.dv[DV_W-1];
        s3_next.t2    = s2_mdd_reg[SH_T2+DL_W-1:SH_T2];
        s3_next.off1  = WIDE_W'($signed({1'b0, cal.c2, {OFF_SCALE{1'b0}}}))
                      + (s2_moff_reg >>> SH_OFF);
        s3_next.sens1 = WIDE_W'($signed({1'b0, cal.c1, {SENS_SCALE{1'b0}}}))
                      + (s2_msens_reg >>> SH_SENS);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_d1_reg    <= d1;
            s1_ok_reg    <= cal.ready;
            s1_dt_reg    <= s1_dt_next;
            s2_d1_reg    <= s1_d1_reg;
            s2_ok_reg    <= s1_ok_reg;
            s2_mt_reg    <= s2_mt_next;
            s2_moff_reg  <= s2_moff_next;
            s2_msens_reg <= s2_msens_next;
            s2_mdd_reg   <= s2_mdd_next;
            s3_reg       <= s3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out       = s3_reg;

endmodule

@@ src/bptc_second_order.sv @@
module bptc_second_order (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  bptc_pkg::bptc_fo_t    fo,
    output logic                  out_valid,
    output bptc_pkg::bptc_so_t    out
);
    import bptc_pkg::*;

    // stage 4: squares and corrected temperature
    logic                       s4_valid_reg;
    logic [RAW_W-1:0]           s4_d1_reg;
    logic                       s4_ok_reg;
    logic                       s4_low_reg;
    logic                       s4_vlow_reg;
    logic signed [TEMP_W:0]     s4_temp_reg, s4_temp_next;
    logic signed [WIDE_W-1:0]   s4_off1_reg;
    logic signed [WIDE_W-1:0]   s4_sens1_reg;
    logic [SQ_W-1:0]            s4_dl2_reg, s4_dl2_next;
    logic [SQ_W-1:0]            s4_dv2_reg, s4_dv2_next;
    logic signed [2*DL_W-1:0]   dl_sq;
    logic signed [2*DV_W-1:0]   dv_sq;

    // stage 5: scaled correction terms
    logic                       s5_valid_reg;
    logic [RAW_W-1:0]           s5_d1_reg;
    logic                       s5_ok_reg;
    logic                       s5_low_reg;
    logic                       s5_vlow_reg;
    logic signed [TEMP_W:0]     s5_temp_reg;
    logic signed [WIDE_W-1:0]   s5_off1_reg;
    logic signed [WIDE_W-1:0]   s5_sens1_reg;
    logic [SQ_W+2:0]            five_dl2;
    logic [SQ_W+3:0]            seven_dv2;
    logic [SQ_W+3:0]            eleven_dv2;
    logic [SQ_W+1:0]            s5_off2_reg;
    logic [SQ_W:0]              s5_sens2_reg;
    logic [SQ_W+3:0]            s5_off3_reg;
    logic [SQ_W+2:0]            s5_sens3_reg;

    // stage 6: corrected offset and sensitivity
    logic                       s6_valid_reg;
    bptc_so_t                   s6_reg, s6_next;
    logic [SQ_W+4:0]            sub_off;
    logic [SQ_W+4:0]            sub_sens;

    assign dl_sq       = fo.dl * fo.dl;
    assign dv_sq       = fo.dv * fo.dv;
    assign s4_dl2_next = dl_sq[SQ_W-1:0];
    assign s4_dv2_next = dv_sq[SQ_W-1:0];
    assign s4_temp_next = (TEMP_W+1)'(fo.temp1)
                        - (fo.low ? $signed({2'b0, fo.t2}) : '0);

    // constant multiples by shift, add and subtract
    assign five_dl2   = {s4_dl2_reg, 2'b00} + (SQ_W+3)'(s4_dl2_reg);
    assign seven_dv2  = {s4_dv2_reg, 3'b000} - (SQ_W+4)'(s4_dv2_reg);
    assign eleven_dv2 = {s4_dv2_reg, 3'b000} + (SQ_W+4)'({s4_dv2_reg, 1'b0})
                      + (SQ_W+4)'(s4_dv2_reg);

    // terms apply below 20 C, the third one below -15 C
    always_comb begin
        sub_off  = '0;
        sub_sens = '0;
        if (s5_low_reg) begin
            sub_off  = (SQ_W+5)'(s5_off2_reg)
                     + (s5_vlow_reg ? (SQ_W+5)'(s5_off3_reg) : '0);
            sub_sens = (SQ_W+5)'(s5_sens2_reg)
                     + (s5_vlow_reg ? (SQ_W+5)'(s5_sens3_reg) : '0);
        end
    end

    always_comb begin
        s6_next      = '0;
        s6_next.d1   = s5_d1_reg;
        s6_next.ok   = s5_ok_reg;
        s6_next.temp = s5_temp_reg;
        s6_next.off  = s5_off1_reg - $signed({2'b0, sub_off});
        s6_next.sens = s5_sens1_reg - $signed({2'b0, sub_sens});
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else if (en) begin
            s4_valid_reg <= in_valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            s4_d1_reg    <= fo.d1;
            s4_ok_reg    <= fo.ok;
            s4_low_reg   <= fo.low;
            s4_vlow_reg  <= fo.vlow;
            s4_temp_reg  <= s4_temp_next;
            s4_off1_reg  <= fo.off1;
            s4_sens1_reg <= fo.sens1;
            s4_dl2_reg   <= s4_dl2_next;
            s4_dv2_reg   <= s4_dv2_next;
            s5_d1_reg    <= s4_d1_reg;
            s5_ok_reg    <= s4_ok_reg;
            s5_low_reg   <= s4_low_reg;
            s5_vlow_reg  <= s4_vlow_reg;
            s5_temp_reg  <= s4_temp_reg;
            s5_off1_reg  <= s4_off1_reg;
            s5_sens1_reg <= s4_sens1_reg;
            s5_off2_reg  <= five_dl2[SQ_W+2:1];
            s5_sens2_reg <= five_dl2[SQ_W+2:2];
            s5_off3_reg  <= seven_dv2;
            s5_sens3_reg <= eleven_dv2[SQ_W+3:1];
            s6_reg       <= s6_next;
        end
    end

    assign out_valid = s6_valid_reg;
    assign out       = s6_reg;

endmodule

@@ src/bptc_pressure.sv @@
module bptc_pressure (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  bptc_pkg::bptc_so_t                  so,
    output logic                                out_valid,
    output logic signed [bptc_pkg::TEMP_W-1:0]  temperature_centi,
    output logic signed [bptc_pkg::PRES_W-1:0]  pressure_centi,
    output logic                                result_valid
);
    import bptc_pkg::*;

    localparam int PL_W   = RAW_W + SENS_LO_W;
    localparam int PH_W   = RAW_W + 1 + WIDE_W - SENS_LO_W;
    localparam int FULL_W = PH_W + SENS_LO_W;
    localparam int Q_W    = FULL_W - SH_PROD;

    // stage 7: partial products of d1 * sens
    logic                       s7_valid_reg;
    logic                       s7_ok_reg;
    logic signed [TEMP_W:0]     s7_temp_reg;
    logic signed [WIDE_W-1:0]   s7_off_reg;
    logic [PL_W-1:0]            s7_pl_reg, s7_pl_next;
    logic signed [PH_W-1:0]     s7_ph_reg, s7_ph_next;

    // stage 8: full product, scaled
    logic                       s8_valid_reg;
    logic                       s8_ok_reg;
    logic signed [TEMP_W:0]     s8_temp_reg;
    logic signed [WIDE_W-1:0]   s8_off_reg;
    logic signed [FULL_W-1:0]   full_prod;
    logic signed [Q_W-1:0]      s8_q_reg;

    // stage 9: output register
    logic                       s9_valid_reg;
    logic                       s9_ok_reg;
    logic signed [TEMP_W-1:0]   s9_temp_reg, s9_temp_next;
    logic signed [PRES_W-1:0]   s9_pres_reg, s9_pres_next;
    logic signed [Q_W:0]        diff;

    assign s7_pl_next = PL_W'(so.d1) * PL_W'(so.sens[SENS_LO_W-1:0]);
    assign s7_ph_next = $signed({1'b0, so.d1}) * $signed(so.sens[WIDE_W-1:SENS_LO_W]);

    assign full_prod = $signed({s7_ph_reg, {SENS_LO_W{1'b0}}})
                     + $signed({{(FULL_W-PL_W){1'b0}}, s7_pl_reg});

    // pressure and zeroed fields when calibration is not trusted
    assign diff         = (Q_W+1)'(s8_q_reg) - (Q_W+1)'(s8_off_reg);
    assign s9_pres_next = s8_ok_reg ? diff[SH_PRES+PRES_W-1:SH_PRES] : '0;
    assign s9_temp_next = s8_ok_reg ? s8_temp_reg[TEMP_W-1:0] : '0;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end else if (en) begin
            s7_valid_reg <= in_valid;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            s7_ok_reg   <= so.ok;
            s7_temp_reg <= so.temp;
            s7_off_reg  <= so.off;
            s7_pl_reg   <= s7_pl_next;
            s7_ph_reg   <= s7_ph_next;
            s8_ok_reg   <= s7_ok_reg;
            s8_temp_reg <= s7_temp_reg;
            s8_off_reg  <= s7_off_reg;
            s8_q_reg    <= full_prod[FULL_W-1:SH_PROD];
            s9_ok_reg   <= s8_ok_reg;
            s9_temp_reg <= s9_temp_next;
            s9_pres_reg <= s9_pres_next;
        end
    end

    assign out_valid         = s9_valid_reg;
    assign temperature_centi = s9_temp_reg;
    assign pressure_centi    = s9_pres_reg;
    assign result_valid      = s9_ok_reg;

endmodule

@@ src/bptc_checker.sv @@
`include "baro_pressure_temp_compensation_macros.svh"

module bptc_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_ready,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [bptc_pkg::TEMP_W-1:0]  m_temperature_centi,
    input  logic signed [bptc_pkg::PRES_W-1:0]  m_pressure_centi,
    input  logic                                m_result_valid
);

    // a stalled result stays offered
    `BPTC_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid, "result dropped while stalled")

    // a stalled result keeps its value
    `BPTC_ASSERT(a_out_stable, m_valid && !m_ready |=> $stable(m_temperature_centi) && $stable(m_pressure_centi) && $stable(m_result_valid), "result changed while stalled")

    // untrusted calibration gives zeroed values
    `BPTC_ASSERT(a_zero_fields, m_valid && !m_result_valid |-> m_temperature_centi == '0 && m_pressure_centi == '0, "nonzero fields with calibration not ready")

    // an empty output slot always lets a new item in
    `BPTC_ASSERT(a_ready_free, !m_valid |-> s_ready, "input blocked with empty output")

    // reset empties the pipeline
    `BPTC_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result offered after reset")

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_temperature_centi (m_temperature_centi),
    .m_pressure_centi    (m_pressure_centi),
    .m_result_valid      (m_result_valid)
);

@@ test/tb_baro_pressure_temp_compensation.sv @@
`timescale 1ns / 1ps

module tb_baro_pressure_temp_compensation;
    import bptc_pkg::*;

    // pipeline depth from input acceptance to result
    localparam int PIPE_LAT    = 9;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 150;
    localparam int RAND_PHASES = 11;

    // register index past the end of the map, writes there are dropped
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

    // typical factory calibration
    localparam logic [CAL_W-1:0] TYP_C1 = 16'd40127;
    localparam logic [CAL_W-1:0] TYP_C2 = 16'd36924;
    localparam logic [CAL_W-1:0] TYP_C3 = 16'd23317;
    localparam logic [CAL_W-1:0] TYP_C4 = 16'd23282;
    localparam logic [CAL_W-1:0] TYP_C5 = 16'd33464;
    localparam logic [CAL_W-1:0] TYP_C6 = 16'd28312;
    localparam logic [RAW_W-1:0] TYP_D1 = 24'd9085466;
    localparam logic [RAW_W-1:0] TYP_D2 = 24'd8569150;
    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [PRES_W-1:0] pres;
        logic                     ok;
    } reading_t;

    // expected readings in acceptance order, plus a private copy of calibration
    class reading_book_t;
        bptc_cal_t cal;
        reading_t  pending[$];
        int        failures;

        function new();
            cal = '0;
            failures = 0;
        endfunction

        function void set_register(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] data);
            case (idx)
                REG_C1: cal.c1 = data;
                REG_C2: cal.c2 = data;
                REG_C3: cal.c3 = data;
                REG_C4: cal.c4 = data;
                REG_C5: cal.c5 = data;
                REG_C6: cal.c6 = data;
                REG_READY: cal.ready = data[0];
                default: ;
            endcase
        endfunction

        // first and second order compensation in 64-bit signed arithmetic
        function reading_t compensate(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
            reading_t r;
            longint d1v, d2v, c1v, c2v, c3v, c4v, c5v, c6v;
            longint dt, temp, off, sens, p, t2, dl, dv, off2, sens2;
            r = '0;
            if (!cal.ready)
                return r;
            d1v = longint'(d1);
            d2v = longint'(d2);
            c1v = longint'(cal.c1);
            c2v = longint'(cal.c2);
            c3v = longint'(cal.c3);
            c4v = longint'(cal.c4);
            c5v = longint'(cal.c5);
            c6v = longint'(cal.c6);
            dt   = d2v - (c5v << C5_SCALE);
            temp = TEMP_REF + ((dt * c6v) >>> SH_TEMP);
            off  = (c2v << OFF_SCALE) + ((c4v * dt) >>> SH_OFF);
            sens = (c1v << SENS_SCALE) + ((c3v * dt) >>> SH_SENS);
            // cold correction, with an extra term when very cold
            if (temp < TEMP_REF) begin
                t2    = (dt * dt) >>> SH_T2;
                dl    = temp - TEMP_REF;
                off2  = (5 * dl * dl) / 2;
                sens2 = (5 * dl * dl) / 4;
                if (temp < TEMP_LOW) begin
                    dv    = temp - TEMP_LOW;
                    off2  = off2 + 7 * dv * dv;
                    sens2 = sens2 + (11 * dv * dv) / 2;
                end
                temp = temp - t2;
                off  = off - off2;
                sens = sens - sens2;
            end
            p = (((d1v * sens) >>> SH_PROD) - off) >>> SH_PRES;
            r.temp = temp[TEMP_W-1:0];
            r.pres = p[PRES_W-1:0];
            r.ok   = 1'b1;
            return r;
        endfunction

        function void note_conversion(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
            pending.push_back(compensate(d1, d2));
        endfunction

        function void check_result(logic signed [TEMP_W-1:0] temp,
                                   logic signed [PRES_W-1:0] pres, logic ok);
            reading_t want;
            if (pending.size() == 0) begin
                $error("unexpected result: temperature_centi %0d pressure_centi %0d",
                       temp, pres);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (temp !== want.temp) begin
                $error("temperature_centi expected %0d got %0d", want.temp, temp);
                failures++;
            end
            if (pres !== want.pres) begin
                $error("pressure_centi expected %0d got %0d", want.pres, pres);
                failures++;
            end
            if (ok !== want.ok) begin
                $error("result_valid expected %0b got %0b", want.ok, ok);
                failures++;
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [IDX_W-1:0]         cfg_index = REG_C1;
    logic [CAL_W-1:0]         cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [RAW_W-1:0]         s_raw_pressure = '0;
    logic [RAW_W-1:0]         s_raw_temperature = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [TEMP_W-1:0] m_temperature_centi;
    logic signed [PRES_W-1:0] m_pressure_centi;
    logic                     m_result_valid;

    reading_book_t book = new();
    bit            gaps_on = 1'b1;
    bit            stalls_on = 1'b1;

    baro_pressure_temp_compensation dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_raw_pressure      (s_raw_pressure),
        .s_raw_temperature   (s_raw_temperature),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_centi (m_temperature_centi),
        .m_pressure_centi    (m_pressure_centi),
        .m_result_valid      (m_result_valid)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: check each accepted item, then choose the next ready level
    int stall_left = 0;
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            book.check_result(m_temperature_centi, m_pressure_centi, m_result_valid);
        if (stall_left == 0 && stalls_on)
            stall_left = pick_gap();
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // run guard
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    // present one conversion pair and hold it until accepted
    task automatic offer_conversion(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_raw_pressure    <= d1;
        s_raw_temperature <= d2;
        do @(posedge aclk); while (!s_ready);
        book.note_conversion(d1, d2);
    endtask

    // stop sending and let every outstanding item come out
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (book.pending.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 2) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        book.set_register(idx, data);
    endtask

    // full register load, with a dropped write past the map
    task automatic program_cal(input bptc_cal_t cal, input logic [CAL_W-1:0] ready_word);
        cfg_write(REG_C1, cal.c1);
        cfg_write(REG_C2, cal.c2);
        cfg_write(REG_C3, cal.c3);
        cfg_write(REG_C4, cal.c4);
        cfg_write(REG_C5, cal.c5);
        cfg_write(REG_C6, cal.c6);
        cfg_write(REG_READY, ready_word);
        cfg_write(REG_SPARE, CAL_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CAL_W-1:0] near_word(logic [CAL_W-1:0] base);
        int v;
        v = int'(base) + $urandom_range(0, 4000) - 2000;
        return v[CAL_W-1:0];
    endfunction

    // calibration sets: fully random, all-extreme, or close to typical
    function automatic bptc_cal_t pick_cal();
        bptc_cal_t c;
        int mode;
        c = '0;
        mode = $urandom_range(0, 2);
        if (mode == 0) begin
            c.c1 = CAL_W'($urandom);
            c.c2 = CAL_W'($urandom);
            c.c3 = CAL_W'($urandom);
            c.c4 = CAL_W'($urandom);
            c.c5 = CAL_W'($urandom);
            c.c6 = CAL_W'($urandom);
        end else if (mode == 1) begin
            c.c1 = {CAL_W{1'($urandom_range(0, 1))}};
            c.c2 = {CAL_W{1'($urandom_range(0, 1))}};
            c.c3 = {CAL_W{1'($urandom_range(0, 1))}};
            c.c4 = {CAL_W{1'($urandom_range(0, 1))}};
            c.c5 = {CAL_W{1'($urandom_range(0, 1))}};
            c.c6 = {CAL_W{1'($urandom_range(0, 1))}};
        end else begin
            c.c1 = near_word(TYP_C1);
            c.c2 = near_word(TYP_C2);
            c.c3 = near_word(TYP_C3);
            c.c4 = near_word(TYP_C4);
            c.c5 = near_word(TYP_C5);
            c.c6 = near_word(TYP_C6);
        end
        return c;
    endfunction

    // raw temperature around the reference point, spread over a random scale, or fully random
    function automatic logic [RAW_W-1:0] pick_raw_temp();
        longint centre, offs, v;
        int k;
        if ($urandom_range(0, 9) < 4)
            return RAW_W'($urandom);
        centre = longint'(book.cal.c5) << C5_SCALE;
        k = $urandom_range(0, 21);
        offs = longint'($urandom_range(0, 1 << k));
        if ($urandom_range(0, 1))
            offs = -offs;
        v = centre + offs;
        if (v < 0)
            v = 0;
        if (v > longint'(RAW_MAX))
            v = longint'(RAW_MAX);
        return v[RAW_W-1:0];
    endfunction

    initial begin
        bptc_cal_t      cal;
        logic [CAL_W-1:0] ready_word;
        logic [RAW_W-1:0] d1;
        longint         ref_d2, dt_edge;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // straight out of reset: calibration not ready
        offer_conversion(TYP_D1, TYP_D2);
        offer_conversion(RAW_MAX, RAW_MAX);
        offer_conversion('0, '0);
        settle_pipeline();

        // typical calibration, warm, cold and very cold boundaries
        cal = '{c1: TYP_C1, c2: TYP_C2, c3: TYP_C3, c4: TYP_C4,
                c5: TYP_C5, c6: TYP_C6, ready: 1'b1};
        program_cal(cal, 16'h0001);
        ref_d2  = longint'(TYP_C5) << C5_SCALE;
        dt_edge = -((longint'(TEMP_REF - TEMP_LOW) << SH_TEMP) / longint'(TYP_C6));
        offer_conversion(TYP_D1, TYP_D2);
        offer_conversion('0, TYP_D2);
        offer_conversion(RAW_MAX, TYP_D2);
        offer_conversion(TYP_D1, ref_d2[RAW_W-1:0]);
        offer_conversion(TYP_D1, RAW_W'(ref_d2 - 1));
        offer_conversion(TYP_D1, RAW_W'(ref_d2 + dt_edge));
        offer_conversion(TYP_D1, RAW_W'(ref_d2 + dt_edge - 1));
        offer_conversion(RAW_MAX, '0);
        offer_conversion('0, '0);
        offer_conversion(RAW_MAX, RAW_MAX);
        offer_conversion('0, RAW_MAX);
        offer_conversion(TYP_D1, 24'd7000000);
        settle_pipeline();

        // all calibration words zero
        program_cal('0, 16'h0001);
        offer_conversion('0, '0);
        offer_conversion(RAW_MAX, RAW_MAX);
        offer_conversion(RAW_MAX, '0);
        settle_pipeline();

        // all calibration words at full scale
        program_cal('1, 16'hFFFF);
        offer_conversion(RAW_MAX, RAW_MAX);
        offer_conversion('0, '0);
        offer_conversion(RAW_MAX, '0);
        settle_pipeline();

        // random phases, each with its own calibration and idling pattern
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            cal = pick_cal();
            ready_word = CAL_W'($urandom);
            ready_word[0] = ($urandom_range(0, 99) < 85);
            program_cal(cal, ready_word);
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                d1 = RAW_W'($urandom);
                if ($urandom_range(0, 19) == 0)
                    d1 = $urandom_range(0, 1) ? RAW_MAX : '0;
                offer_conversion(d1, pick_raw_temp());
            end
            settle_pipeline();
        end

        if (book.failures == 0 && book.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/bptc_pkg.sv
src/bptc_cal_regs.sv
src/bptc_first_order.sv
src/bptc_second_order.sv
src/bptc_pressure.sv
src/baro_pressure_temp_compensation.sv
src/bptc_checker.sv
test/tb_baro_pressure_temp_compensation.sv
